// File: rtl/ordered_list_insert_delete_search_unit_macros.svh
// Assertion macros used by the ordered list datapath
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_UNIT_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset
`define OLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on every clock edge outside reset
`define OLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/oli_pkg.sv
// Types and constants shared by the ordered list unit
`default_nettype none

package oli_pkg;

  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_LOCATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_INS_WRITE,
    ST_DONE
  } state_e;

  // Input beat
  typedef struct packed {
    cmd_e                     cmd;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;
  } in_t;

  // Result beat
  typedef struct packed {
    logic                     ok;
    logic signed [VAL_W-1:0]  read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         count;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // latch the accepted beat
    logic step;      // advance the memory walk by one entry
    logic wr_val;    // write the new value at its slot
    logic res_load;  // commit length and load the result register
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic in_go;     // incoming command needs a memory walk
    logic is_insert; // latched command is an insert
    logic walk_end;  // walk finished this cycle
    logic out_busy;  // result register still holds an untaken beat
  } status_t;

endpackage

`default_nettype wire

// File: rtl/oli_ctrl.sv
// Sequencing state machine for the ordered list unit
`default_nettype none

module oli_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  oli_pkg::status_t status_i,
  output oli_pkg::ctrl_t   ctrl_o
);
  import oli_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    in_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = status_i.in_go ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        ctrl_o.step = 1'b1;
        if (status_i.walk_end) begin
          state_d = status_i.is_insert ? ST_INS_WRITE : ST_DONE;
        end
      end
      ST_INS_WRITE: begin
        ctrl_o.wr_val = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          ctrl_o.res_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/oli_dp.sv
// Entry memory, length, walk counters and result register of the ordered list
`default_nettype none
`include "ordered_list_insert_delete_search_unit_macros.svh"

module oli_dp #(
  parameter int DEPTH = oli_pkg::DEPTH_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  oli_pkg::in_t     in_data_i,
  input  oli_pkg::ctrl_t   ctrl_i,
  output oli_pkg::status_t status_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output oli_pkg::out_t    out_data_o
);
  import oli_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // Entry memory
  logic [VAL_W-1:0] mem [DEPTH];
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata;
  logic [VAL_W-1:0] rdata_q;

  // Control registers
  logic [LW-1:0]    len_q, len_d;
  logic             pend_q, pend_d;
  logic             cap_q, cap_d;
  logic             res_valid_q, res_valid_d;

  // Working registers
  cmd_e             cmd_q, cmd_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [LW-1:0]    k_q, k_d;
  logic [LW-1:0]    lim_q, lim_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;
  logic             ok_q, ok_d;
  logic [VAL_W-1:0] rd_q, rd_d;
  logic [POS_W-1:0] found_q, found_d;
  out_t             res_q, res_d;

  // Widened operands for compares
  logic [CW-1:0]    in_pos_ext, pos_ext, len_ext, k_ext, pm1_ext, in_pm1_ext;
  logic [CW-1:0]    found_ext, len_d_ext;
  logic [LW-1:0]    k_m1;
  logic [LW-1:0]    k_ld;      // walk start for the beat being taken
  logic             issue, hit, in_go;

  assign in_pos_ext = CW'(in_data_i.position);
  assign in_pm1_ext = in_pos_ext - ONE_C;
  assign pos_ext    = CW'(pos_q);
  assign pm1_ext    = pos_ext - ONE_C;
  assign len_ext    = CW'(len_q);
  assign k_ext      = CW'(k_q);
  assign k_m1       = k_q - LW'(1);
  assign found_ext  = CW'(pend_addr_q) + ONE_C;

  // Bounds check of the incoming command
  always_comb begin
    case (in_data_i.cmd)
      CMD_INSERT: in_go = (in_pos_ext != '0) && (in_pos_ext <= len_ext + ONE_C)
                          && (len_ext < DEPTH_C);
      CMD_DELETE,
      CMD_GET:    in_go = (in_pos_ext != '0) && (in_pos_ext <= len_ext);
      default:    in_go = 1'b1;
    endcase
  end

  // Locate match on the entry read last cycle
  assign hit = (cmd_q == CMD_LOCATE) && pend_q && (rdata_q == val_q);

  // Walk step: one memory read issued per cycle
  always_comb begin
    issue       = 1'b0;
    raddr       = k_q[AW-1:0];
    pend_addr_d = pend_addr_q;
    k_d         = k_q;
    case (cmd_q)
      CMD_INSERT: begin
        // move entries up from the tail down to the insert slot
        issue = k_ext >= pos_ext;
        raddr = k_m1[AW-1:0];
        if (ctrl_i.step && issue) begin
          pend_addr_d = k_q[AW-1:0];
          k_d         = k_m1;
        end
      end
      CMD_DELETE,
      CMD_GET: begin
        // first read is the reported entry, later reads move down one place
        issue = k_q < lim_q;
        if (ctrl_i.step && issue) begin
          pend_addr_d = k_m1[AW-1:0];
          k_d         = k_q + LW'(1);
        end
      end
      default: begin
        issue = (k_q < len_q) && !hit;
        if (ctrl_i.step && issue) begin
          pend_addr_d = k_q[AW-1:0];
          k_d         = k_q + LW'(1);
        end
      end
    endcase
    // start point of the walk for a newly taken beat
    if (ctrl_i.load) begin
      k_d = k_ld;
    end
    re     = ctrl_i.step && issue;
    pend_d = re;
  end

  // Status to the controller
  always_comb begin
    status_o.in_go     = in_go;
    status_o.is_insert = (cmd_q == CMD_INSERT);
    status_o.out_busy  = res_valid_q && !out_ready_i;
    case (cmd_q)
      CMD_LOCATE: status_o.walk_end = hit || (!pend_q && !(k_q < len_q));
      default:    status_o.walk_end = !issue;
    endcase
  end

  // Memory write: pending move or the inserted value
  always_comb begin
    we    = 1'b0;
    waddr = pend_addr_q;
    wdata = rdata_q;
    if (ctrl_i.wr_val) begin
      we    = 1'b1;
      waddr = pm1_ext[AW-1:0];
      wdata = val_q;
    end else if (pend_q && ((cmd_q == CMD_INSERT) ||
                            ((cmd_q == CMD_DELETE) && !cap_q))) begin
      we = 1'b1;
    end
  end

  // Command latch, result capture and commit
  always_comb begin
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    val_d       = val_q;
    lim_d       = lim_q;
    cap_d       = cap_q;
    ok_d        = ok_q;
    rd_d        = rd_q;
    found_d     = found_q;
    len_d       = len_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    len_d_ext   = len_ext;
    k_ld        = '0;

    if (ctrl_i.load) begin
      cmd_d   = in_data_i.cmd;
      pos_d   = in_data_i.position;
      val_d   = in_data_i.value;
      rd_d    = '0;
      found_d = '0;
      cap_d   = 1'b1;
      ok_d    = in_go && (in_data_i.cmd != CMD_LOCATE);
      case (in_data_i.cmd)
        CMD_INSERT: begin
          k_ld  = len_q;
          lim_d = len_q;
        end
        CMD_DELETE: begin
          k_ld  = in_pm1_ext[LW-1:0];
          lim_d = len_q;
        end
        CMD_GET: begin
          k_ld  = in_pm1_ext[LW-1:0];
          lim_d = in_pos_ext[LW-1:0];
        end
        default: begin
          k_ld  = '0;
          lim_d = len_q;
        end
      endcase
    end

    // capture of the reported entry
    if (pend_q && cap_q && ((cmd_q == CMD_DELETE) || (cmd_q == CMD_GET))) begin
      rd_d  = rdata_q;
      cap_d = 1'b0;
    end

    if (hit) begin
      ok_d    = 1'b1;
      found_d = found_ext[POS_W-1:0];
    end

    if (res_valid_q && out_ready_i) begin
      res_valid_d = 1'b0;
    end

    if (ctrl_i.res_load) begin
      if (ok_q && (cmd_q == CMD_INSERT)) begin
        len_d = len_q + LW'(1);
      end else if (ok_q && (cmd_q == CMD_DELETE)) begin
        len_d = len_q - LW'(1);
      end
      len_d_ext            = CW'(len_d);
      res_d.ok             = ok_q;
      res_d.read_value     = rd_q;
      res_d.found_position = found_q;
      res_d.count          = len_d_ext[POS_W-1:0];
      res_valid_d          = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pend_q      <= 1'b0;
      cap_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      pend_q      <= pend_d;
      cap_q       <= cap_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    k_q         <= k_d;
    lim_q       <= lim_d;
    pend_addr_q <= pend_addr_d;
    ok_q        <= ok_d;
    rd_q        <= rd_d;
    found_q     <= found_d;
    res_q       <= res_d;
  end

  // Single write, single registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  // Checks
  `OLI_ASSERT(a_len_bound, len_ext <= DEPTH_C, "list length past depth")
  `OLI_ASSERT_IMP(a_wr_no_clash, ctrl_i.wr_val, !pend_q, "insert write collides with a move")
  `OLI_ASSERT_IMP(a_res_no_overwrite, ctrl_i.res_load, !res_valid_q || out_ready_i,
                  "result overwritten before taken")
  `OLI_ASSERT(a_len_commit, !ctrl_i.res_load |=> len_q == $past(len_q),
              "length changed outside commit")

endmodule

`default_nettype wire

// File: rtl/ordered_list_insert_delete_search_unit.sv
// Top level of the ordered list unit: controller and datapath
// An ordered list of up to DEPTH signed 32-bit entries held in a memory with
// one write and one registered read per cycle, with insert,
// delete, get and locate commands on a valid/ready input channel and one
// result beat per command on a valid/ready output channel. The block takes
// one command at a time; shifting and searching walk the memory one entry a
// cycle, and a command that fails its bounds check skips the walk. A finished
// command waits to load its result while the previous result is untaken.
// A new command is accepted the cycle after the result is loaded, while that
// result still waits to be taken. The entry memory is not cleared at reset;
// only positions inside the current length are ever read.
`default_nettype none

module ordered_list_insert_delete_search_unit #(
  parameter int DEPTH = oli_pkg::DEPTH_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  oli_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  output oli_pkg::out_t out_data_o
);
  import oli_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  oli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  oli_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: verif/tb_ordered_list_insert_delete_search_unit.sv
// Self-checking testbench for the ordered list insert/delete/search unit
`default_nettype none

module tb_ordered_list_insert_delete_search_unit;
  import oli_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BEATS = 510;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  ordered_list_insert_delete_search_unit #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the list contents, updated as each command beat is taken
  logic signed [VAL_W-1:0] list_entries [LIST_DEPTH];
  int unsigned             list_length = 0;
  out_t                    awaited_results [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  hold_off_req = 0;
  int  stall_left = 0;
  bit  steady_flow = 1'b0;

  // Gap lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Values: small pool to give repeats, extremes, or anything at all
  function automatic logic signed [VAL_W-1:0] pick_list_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $signed($urandom_range(0, 6)) - 3;
    if (r == 4) return 32'sh7fff_ffff;
    if (r == 5) return 32'sh8000_0000;
    return $urandom;
  endfunction

  // Expected result of one command; updates the mirrored list
  task automatic compute_list_reply(input in_t beat, output out_t reply);
    int unsigned pos;
    pos = beat.position;
    reply = '0;
    case (beat.cmd)
      CMD_INSERT: begin
        if (pos >= 1 && pos <= list_length + 1 && list_length < LIST_DEPTH) begin
          for (int k = int'(list_length); k >= int'(pos); k--)
            list_entries[k] = list_entries[k-1];
          list_entries[pos-1] = beat.value;
          list_length++;
          reply.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos >= 1 && pos <= list_length) begin
          reply.read_value = list_entries[pos-1];
          for (int k = int'(pos); k < int'(list_length); k++)
            list_entries[k-1] = list_entries[k];
          list_length--;
          reply.ok = 1'b1;
        end
      end
      CMD_GET: begin
        if (pos >= 1 && pos <= list_length) begin
          reply.read_value = list_entries[pos-1];
          reply.ok = 1'b1;
        end
      end
      default: begin
        // locate: first match wins, position field unused
        for (int k = 0; k < int'(list_length); k++) begin
          if (list_entries[k] == beat.value) begin
            reply.found_position = POS_W'(k + 1);
            reply.ok = 1'b1;
            break;
          end
        end
      end
    endcase
    reply.count = POS_W'(list_length);
  endtask

  // Offer one command beat and wait for it to be taken
  task automatic send_list_beat(input cmd_e c, input logic [POS_W-1:0] p,
                                input logic signed [VAL_W-1:0] v);
    int   gap;
    in_t  beat;
    out_t reply;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat.cmd      = c;
    beat.position = p;
    beat.value    = v;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    compute_list_reply(beat, reply);
    awaited_results.push_back(reply);
  endtask

  // Stop offering and wait until every expected result has come
  task automatic wait_list_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, plus a long hold when one is requested
  always @(posedge clk_i) begin
    if (hold_off_req > 0) begin
      stall_left = hold_off_req;
      hold_off_req = 0;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data_o.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_data_o.ok);
          mismatch_count++;
        end
        if (out_data_o.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value,
                 out_data_o.read_value);
          mismatch_count++;
        end
        if (out_data_o.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d", want.found_position,
                 out_data_o.found_position);
          mismatch_count++;
        end
        if (out_data_o.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data_o.count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ordered_list_insert_delete_search_unit: mismatch");
      $finish;
    end
  end

  // Commands on an empty list, bad insert positions, first insert
  task automatic test_empty_list();
    send_list_beat(CMD_GET, 5'd1, 32'sd0);
    send_list_beat(CMD_DELETE, 5'd1, 32'sd0);
    send_list_beat(CMD_LOCATE, 5'd0, 32'sd0);
    send_list_beat(CMD_INSERT, 5'd0, 32'sd5);
    send_list_beat(CMD_INSERT, 5'd2, 32'sd5);
    send_list_beat(CMD_INSERT, 5'd1, 32'sh7fff_ffff);
  endtask

  // Fill to the top from both ends, then try to overfill
  task automatic test_fill_and_overflow();
    int k;
    send_list_beat(CMD_INSERT, 5'd1, 32'sh8000_0000);
    send_list_beat(CMD_INSERT, 5'd2, -32'sd1);
    k = 0;
    while (list_length < LIST_DEPTH) begin
      if (k % 2 == 0)
        send_list_beat(CMD_INSERT, POS_W'(list_length + 1), 32'sh5555_5555);
      else
        send_list_beat(CMD_INSERT, 5'd1, 32'shaaaa_aaaa);
      k++;
    end
    send_list_beat(CMD_INSERT, 5'd17, 32'sd1);
    send_list_beat(CMD_INSERT, 5'd31, 32'sd1);
  endtask

  // Reads at the last slot and beyond, locate with repeats and misses
  task automatic test_lookup();
    send_list_beat(CMD_GET, 5'd16, 32'sd0);
    send_list_beat(CMD_GET, 5'd17, 32'sd0);
    send_list_beat(CMD_LOCATE, 5'd31, 32'sh5555_5555);
    send_list_beat(CMD_LOCATE, 5'd0, 32'sd12345);
  endtask

  // Deletes at the last and first slot and at bad positions
  task automatic test_delete_edges();
    send_list_beat(CMD_DELETE, 5'd16, 32'sd0);
    send_list_beat(CMD_DELETE, 5'd1, 32'sd0);
    send_list_beat(CMD_DELETE, 5'd0, 32'sd0);
    send_list_beat(CMD_DELETE, 5'd31, 32'sd0);
  endtask

  // Long hold on the result side so the unit stalls its input
  task automatic test_backpressure();
    steady_flow = 1'b1;
    wait_list_idle();
    hold_off_req = 300;
    for (int k = 0; k < 8; k++)
      send_list_beat(cmd_e'((k % 2) ? CMD_GET : CMD_LOCATE), POS_W'(k + 1),
                     pick_list_value());
    steady_flow = 1'b0;
    wait_list_idle();
  endtask

  // Random mix, alternating phases of growth and shrinkage
  task automatic test_random_mix();
    int r;
    int ins_w;
    int del_w;
    cmd_e c;
    logic [POS_W-1:0] p;
    logic signed [VAL_W-1:0] v;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      steady_flow = (i >= 200 && i < 260);
      ins_w = ((i / 60) % 2 == 0) ? 55 : 15;
      del_w = 70 - ins_w;
      r = $urandom_range(0, 99);
      if (r < ins_w) c = CMD_INSERT;
      else if (r < ins_w + del_w) c = CMD_DELETE;
      else if (r < 85) c = CMD_GET;
      else c = CMD_LOCATE;
      // mostly legal positions, some noise over the whole field
      if ($urandom_range(0, 9) == 0)
        p = POS_W'($urandom_range(0, 31));
      else if (c == CMD_INSERT)
        p = POS_W'($urandom_range(1, list_length + 1));
      else
        p = (list_length == 0) ? 5'd1 : POS_W'($urandom_range(1, list_length));
      if (c == CMD_LOCATE && list_length > 0 && $urandom_range(0, 9) < 6)
        v = list_entries[$urandom_range(0, list_length - 1)];
      else
        v = pick_list_value();
      send_list_beat(c, p, v);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_fill_and_overflow();
    test_lookup();
    test_delete_edges();
    test_backpressure();
    test_random_mix();
    wait_list_idle();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("ordered_list_insert_delete_search_unit: match");
    else
      $display("ordered_list_insert_delete_search_unit: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/oli_pkg.sv
rtl/oli_ctrl.sv
rtl/oli_dp.sv
rtl/ordered_list_insert_delete_search_unit.sv
verif/tb_ordered_list_insert_delete_search_unit.sv
